[src/smooth_vertex_normal_accumulator_core_defines.svh]
// assertion macros used by the normal accumulator back end
`ifndef SMOOTH_VERTEX_NORMAL_ACCUMULATOR_CORE_DEFINES_SVH
`define SMOOTH_VERTEX_NORMAL_ACCUMULATOR_CORE_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define SVN_ASSERT_IMP(lbl, clk, rst_n, lhs, rhs) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define SVN_ASSERT_NEXT(lbl, clk, rst_n, lhs, rhs) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

[src/svna_pkg.sv]
// package: widths, kinds and shared types of the normal accumulator
package svna_pkg;
    localparam int MaxVertices = 1024;
    localparam int IdxBits     = 10;
    localparam int CountBits   = 8;
    localparam int PosBits     = 24;
    localparam int UnitBits    = 16;
    localparam int SumBits     = 24;
    localparam int UnitOne     = 16384;
    localparam int QueueDepth  = 4;
    localparam int QueuePtrBits = 2;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_TRI   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]             kind;
        logic [IdxBits-1:0]     vertex_index;
        logic signed [PosBits-1:0] pos_x;
        logic signed [PosBits-1:0] pos_y;
        logic signed [PosBits-1:0] pos_z;
        logic [IdxBits-1:0]     corner_a;
        logic [IdxBits-1:0]     corner_b;
        logic [IdxBits-1:0]     corner_c;
    } t_cmd;

    typedef struct packed {
        logic signed [UnitBits-1:0] nrm_x;
        logic signed [UnitBits-1:0] nrm_y;
        logic signed [UnitBits-1:0] nrm_z;
        logic                       no_faces;
    } t_res;

    // queue status inside the front
    typedef struct packed {
        logic push;
        logic full;
    } t_qstat;
endpackage

[src/svna_if.sv]
// valid/ready channel carrying one payload beat
interface svna_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/svna_front.sv]
// front: accepts command beats into a short queue
module svna_front import svna_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cmd       i_cmd,
    output logic       o_ready,
    input  logic       i_pop,
    output logic       o_avail,
    output t_cmd       o_cmd
);
    t_cmd r_q [QueueDepth];
    logic [QueuePtrBits-1:0] r_wp, r_rp;
    logic [QueuePtrBits:0]   r_cnt;
    t_qstat st;

    assign st.full  = (r_cnt == 3'(QueueDepth));
    assign st.push  = i_valid && !st.full;
    assign o_ready  = !st.full;
    assign o_avail  = (r_cnt != '0);
    assign o_cmd    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (st.push) r_q[r_wp] <= i_cmd;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (st.push) r_wp <= r_wp + 1'b1;
            if (i_pop)   r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {2'b0, st.push} - {2'b0, i_pop};
        end
    end
endmodule

[src/svna_back.sv]
// back: sequencer doing stores, face normals, queries and clears
module svna_back import svna_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_avail,
    input  t_cmd i_cmd,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);
    `include "smooth_vertex_normal_accumulator_core_defines.svh"

    localparam logic [4:0] S_INIT = 5'd0, S_IDLE = 5'd1, S_RD = 5'd2, S_RDW = 5'd3,
        S_CROSS = 5'd4, S_MUL = 5'd5, S_SHIFT = 5'd6, S_SQ = 5'd7, S_SQRT = 5'd8,
        S_DIV = 5'd9, S_UPD_RD = 5'd10, S_UPD_WAIT = 5'd11, S_UPD_WR = 5'd12,
        S_Q_RD = 5'd13, S_Q_WAIT = 5'd14, S_Q_DIV = 5'd15, S_OUT = 5'd16,
        S_CLR = 5'd17, S_SQ2 = 5'd18;

    logic [4:0] r_st;
    t_cmd r_cmd;
    logic [71:0] r_pos [MaxVertices];
    logic [3*SumBits-1:0] r_sum [MaxVertices];
    logic [CountBits-1:0] r_cnt_mem [MaxVertices];
    logic [IdxBits-1:0] r_ra;
    logic [71:0] r_pd;
    logic [3*SumBits-1:0] r_sd;
    logic [CountBits-1:0] r_cd;
    logic signed [PosBits-1:0] r_p [3][3];
    logic [1:0] r_k;
    logic signed [PosBits:0] r_e1 [3], r_e2 [3];
    logic signed [51:0] r_pr [6];
    logic [50:0] r_m [3];
    logic [29:0] r_r [3];
    logic [61:0] r_qs;
    logic [63:0] r_sv, r_sr, r_sb;
    logic [31:0] r_root;
    logic [45:0] r_num, r_den;
    logic [15:0] r_quo;
    logic [4:0]  r_it;
    logic signed [UnitBits-1:0] r_u [3];
    logic [IdxBits:0] r_clr;
    logic r_ovalid;
    t_res r_res;
    logic [2:0] r_neg;
    logic r_zero;

    // memories
    logic        pos_we, sum_we;
    logic [IdxBits-1:0] mem_wa;
    logic [3*SumBits-1:0] sum_wd;
    logic [CountBits-1:0] cnt_wd;
    always_ff @(posedge i_clk) begin
        if (pos_we) r_pos[i_cmd.vertex_index] <= {i_cmd.pos_x, i_cmd.pos_y, i_cmd.pos_z};
        if (sum_we) begin
            r_sum[mem_wa] <= sum_wd;
            r_cnt_mem[mem_wa] <= cnt_wd;
        end
        r_pd <= r_pos[r_ra];
        r_sd <= r_sum[r_ra];
        r_cd <= r_cnt_mem[r_ra];
    end

    logic [50:0] mx;
    logic [5:0]  sh;
    logic [63:0] tb;
    logic [46:0] dtry;
    logic signed [SumBits-1:0] cs [3];
    logic [SumBits-1:0] mag;
    always_comb begin
        pos_we = (r_st == S_IDLE) && i_avail && i_cmd.kind == KIND_WRITE;
        sum_we = 1'b0;
        mem_wa = r_ra;
        sum_wd = r_sd;
        cnt_wd = r_cd;
        if (r_st == S_CLR) begin
            sum_we = 1'b1; mem_wa = r_clr[IdxBits-1:0]; sum_wd = '0; cnt_wd = '0;
        end
        if (r_st == S_UPD_WR && r_cd != {CountBits{1'b1}}) begin
            sum_we = 1'b1;
            for (int i = 0; i < 3; i++)
                sum_wd[SumBits*(2-i) +: SumBits] = r_sd[SumBits*(2-i) +: SumBits]
                    + SumBits'(r_u[i]);
            cnt_wd = r_cd + 1'b1;
        end
        mx = r_m[0];
        if (r_m[1] > mx) mx = r_m[1];
        if (r_m[2] > mx) mx = r_m[2];
        sh = '0;
        for (int s = 21; s >= 1; s--)
            if ((mx >> s) != '0 && (mx >> (s - 1)) >= 51'(1 << 30) && sh == '0)
                sh = 6'(s);
        tb = r_sb;
        dtry = {1'b0, r_num} - {1'b0, r_den};
        for (int i = 0; i < 3; i++) cs[i] = r_sd[SumBits*(2-i) +: SumBits];
        mag = cs[r_k][SumBits-1] ? -cs[r_k] : cs[r_k];
    end

    assign o_pop   = (r_st == S_IDLE) && i_avail;
    assign o_valid = r_ovalid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_INIT; r_clr <= '0; r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && r_st != S_OUT) r_ovalid <= 1'b0;
            unique case (r_st)
                S_INIT: begin
                    r_clr <= '0;
                    r_st <= S_CLR;
                end
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (IdxBits+1)'(MaxVertices - 1)) r_st <= S_IDLE;
                end
                S_IDLE: if (i_avail) begin
                    r_cmd <= i_cmd;
                    r_k <= 2'd0;
                    unique case (i_cmd.kind)
                        KIND_WRITE: r_st <= S_IDLE;
                        KIND_TRI: begin r_ra <= i_cmd.corner_a; r_st <= S_RD; end
                        KIND_QUERY: begin r_ra <= i_cmd.vertex_index; r_st <= S_Q_RD; end
                        default: begin r_clr <= '0; r_st <= S_CLR; end
                    endcase
                end
                S_RD: begin
                    // address is on r_ra now, its data is registered and taken in S_RDW
                    r_k <= r_k + 1'b1;
                    r_ra <= (r_k == 2'd0) ? r_cmd.corner_b : r_cmd.corner_c;
                    r_st <= S_RDW;
                end
                S_RDW: begin
                    r_p[r_k - 2'd1][0] <= r_pd[71:48];
                    r_p[r_k - 2'd1][1] <= r_pd[47:24];
                    r_p[r_k - 2'd1][2] <= r_pd[23:0];
                    r_st <= (r_k == 2'd3) ? S_CROSS : S_RD;
                    if (r_k == 2'd3) r_k <= 2'd0;
                end
                S_CROSS: begin
                    for (int i = 0; i < 3; i++) begin
                        r_e1[i] <= (PosBits+1)'(r_p[1][i]) - (PosBits+1)'(r_p[0][i]);
                        r_e2[i] <= (PosBits+1)'(r_p[2][i]) - (PosBits+1)'(r_p[0][i]);
                    end
                    r_st <= S_MUL;
                end
                S_MUL: begin
                    r_pr[0] <= 52'(r_e1[1] * r_e2[2]); r_pr[1] <= 52'(r_e1[2] * r_e2[1]);
                    r_pr[2] <= 52'(r_e1[2] * r_e2[0]); r_pr[3] <= 52'(r_e1[0] * r_e2[2]);
                    r_pr[4] <= 52'(r_e1[0] * r_e2[1]); r_pr[5] <= 52'(r_e1[1] * r_e2[0]);
                    r_st <= S_SHIFT;
                end
                S_SHIFT: begin
                    for (int i = 0; i < 3; i++) begin
                        r_neg[i] <= (r_pr[2*i] < r_pr[2*i+1]);
                        r_m[i] <= (r_pr[2*i] < r_pr[2*i+1]) ? 51'(r_pr[2*i+1] - r_pr[2*i])
                                                             : 51'(r_pr[2*i] - r_pr[2*i+1]);
                    end
                    r_st <= S_SQ;
                end
                S_SQ: begin
                    for (int i = 0; i < 3; i++) r_r[i] <= 30'(r_m[i] >> sh);
                    r_st <= S_SQ2;
                end
                S_SQ2: begin
                    r_qs <= 62'(r_k == 2'd0 ? 62'd0 : r_qs) + 62'(r_r[r_k] * r_r[r_k]);
                    r_k <= r_k + 1'b1;
                    if (r_k == 2'd2) begin
                        r_k <= 2'd0; r_it <= '0; r_st <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    // one root bit per cycle, restoring
                    if (r_it == 5'd0) begin
                        r_sv <= {2'b0, r_qs}; r_sr <= '0; r_sb <= 64'd1 << 62;
                        r_it <= 5'd1;
                        r_zero <= (r_qs == '0);
                    end else if (tb == '0) begin
                        r_root <= r_sr[31:0];
                        r_k <= 2'd0; r_it <= '0;
                        r_st <= r_zero ? S_UPD_RD : S_DIV;
                        if (r_zero) for (int i = 0; i < 3; i++) r_u[i] <= '0;
                        if (r_zero) r_ra <= r_cmd.corner_a;
                    end else begin
                        if (r_sv >= r_sr + tb) begin
                            r_sv <= r_sv - (r_sr + tb); r_sr <= (r_sr >> 1) + tb;
                        end else r_sr <= r_sr >> 1;
                        r_sb <= tb >> 2;
                    end
                end
                S_DIV: begin
                    // restoring divide, 15 quotient bits per component
                    if (r_it == 5'd0) begin
                        r_num <= {2'b0, r_r[r_k], 14'd0} + 46'(r_root >> 1);
                        r_den <= {r_root, 14'd0};
                        r_quo <= '0; r_it <= 5'd1;
                    end else if (r_it <= 5'd15) begin
                        if (!dtry[46]) begin
                            r_num <= dtry[45:0]; r_quo <= {r_quo[14:0], 1'b1};
                        end else r_quo <= {r_quo[14:0], 1'b0};
                        r_den <= r_den >> 1;
                        r_it <= r_it + 1'b1;
                    end else begin
                        logic [15:0] u;
                        u = (r_quo > 16'(UnitOne)) ? 16'(UnitOne) : r_quo;
                        r_u[r_k] <= r_neg[r_k] ? -u : u;
                        r_it <= '0;
                        r_k <= r_k + 1'b1;
                        if (r_k == 2'd2) begin
                            r_k <= 2'd0; r_ra <= r_cmd.corner_a; r_st <= S_UPD_RD;
                        end
                    end
                end
                S_UPD_RD: r_st <= S_UPD_WAIT;
                S_UPD_WAIT: r_st <= S_UPD_WR;
                S_UPD_WR: begin
                    r_k <= r_k + 1'b1;
                    r_ra <= (r_k == 2'd0) ? r_cmd.corner_b : r_cmd.corner_c;
                    r_st <= (r_k == 2'd2) ? S_IDLE : S_UPD_RD;
                end
                S_Q_RD: r_st <= S_Q_WAIT;
                // result register is reused, wait until the previous beat has left
                S_Q_WAIT: if (!r_ovalid) begin
                    r_k <= 2'd0; r_it <= '0; r_st <= S_Q_DIV;
                end
                S_Q_DIV: begin
                    if (r_cd == '0) begin
                        r_res <= '{nrm_x: '0, nrm_y: '0, nrm_z: '0, no_faces: 1'b1};
                        r_st <= S_OUT;
                    end else if (r_it == 5'd0) begin
                        r_num <= 46'(mag) + 46'(r_cd >> 1);
                        // the average never needs more than 15 quotient bits
                        r_den <= 46'(r_cd) << 14;
                        r_quo <= '0; r_it <= 5'd1;
                    end else if (r_it <= 5'd15) begin
                        r_den <= r_den >> 1;
                        if (!dtry[46]) begin
                            r_num <= dtry[45:0]; r_quo <= {r_quo[14:0], 1'b1};
                        end else r_quo <= {r_quo[14:0], 1'b0};
                        r_it <= r_it + 1'b1;
                    end else begin
                        logic [15:0] v;
                        v = cs[r_k][SumBits-1] ? -r_quo : r_quo;
                        if (r_k == 2'd0) r_res.nrm_x <= v;
                        if (r_k == 2'd1) r_res.nrm_y <= v;
                        if (r_k == 2'd2) r_res.nrm_z <= v;
                        r_res.no_faces <= 1'b0;
                        r_it <= '0; r_k <= r_k + 1'b1;
                        if (r_k == 2'd2) r_st <= S_OUT;
                    end
                end
                S_OUT: if (!r_ovalid || i_ready) begin
                    r_ovalid <= 1'b1; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `SVN_ASSERT_IMP(a_no_pop_busy, i_clk, i_rst_n, o_pop, r_st == S_IDLE)
    `SVN_ASSERT_IMP(a_nofaces_zero, i_clk, i_rst_n, o_valid && o_res.no_faces,
        o_res.nrm_x == '0 && o_res.nrm_y == '0 && o_res.nrm_z == '0)
    `SVN_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
endmodule

[src/smooth_vertex_normal_accumulator_core.sv]
// top level: smoothed vertex normal accumulator
// a triangle holds the back end for three corner reads, a square root and three
// divisions, then three read-modify-writes; a degenerate one skips the divisions
// a query reads its vertex and divides each component up to its result beat,
// skipping the divisions with no faces, and waits while the previous beat is held;
// a clear and the sweep after reset set every vertex's sums and counts to zero
module smooth_vertex_normal_accumulator_core import svna_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    svna_if.sink   i_cmd,
    svna_if.source o_res
);
    logic pop, avail;
    t_cmd qcmd;
    t_res res;

    svna_front u_front (
        .i_clk, .i_rst_n, .i_valid(i_cmd.valid), .i_cmd(i_cmd.data),
        .o_ready(i_cmd.ready), .i_pop(pop), .o_avail(avail), .o_cmd(qcmd)
    );
    svna_back u_back (
        .i_clk, .i_rst_n, .i_avail(avail), .i_cmd(qcmd), .o_pop(pop),
        .o_valid(o_res.valid), .i_ready(o_res.ready), .o_res(res)
    );
    assign o_res.data = res;
endmodule
